[hdl/lpbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbd_pkg
// Types and constants shared by the bucket deframer modules.
// ----------------------------------------------------------------------------
package lpbd_pkg;

  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned NUM_BUCKETS = 64;
  localparam int unsigned IDX_W       = $clog2(NUM_BUCKETS);
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES + 1);

  localparam int unsigned HDR_BYTES   = 10;
  localparam int unsigned POS_W       = $clog2(HDR_BYTES);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd1;

  typedef enum logic [2:0] {
    EV_BYTE        = 3'd0,
    EV_BUCKET_END  = 3'd1,
    EV_STREAM_DONE = 3'd2,
    EV_BAD_BUCKET  = 3'd3,
    EV_AFTER_DONE  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  // One classified byte travelling from the parser to the fill-count stage.
  typedef struct packed {
    event_e           kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/length_prefixed_bucket_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each result passes the command queue, fill-count stage and output register.
// Throughput: one byte per cycle while out_stall_i is low, into any mix
// of buckets; set by the fill-count read-modify-write through the bucket
// RAM, which a one-entry forwarding register closes for back-to-back bytes.
// Reset: asynchronous, all control state cleared at once; fill counts read
// as zero through per-bucket written flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// length_prefixed_bucket_deframer
// Splits a stream of length-prefixed records into per-bucket body bytes with
// block boundaries, bucket end-of-file and stream completion events.
// ----------------------------------------------------------------------------
module length_prefixed_bucket_deframer
  import lpbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Byte input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            byte_in_i,
  // Event output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 event_res_o,
  output logic [7:0]                 data_out_o,
  output logic [IDX_W-1:0]           bucket_index_o,
  output logic                       block_end_o,
  output logic [FILL_W-1:0]          block_length_o
);

  // The front end parses headers and classifies every byte into at most one
  // command. Header bytes produce nothing until the tenth, which is checked
  // against the bucket window and the live count.
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  lpbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .byte_in_i   (byte_in_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // The queue decouples the two halves, so that an output stall only holds
  // the input once the queue has filled.
  lpbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  // The back end keeps the per-bucket fill counts and drives the output
  // register. Non-byte events pass straight through it.
  lpbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .data_out_o     (data_out_o),
    .bucket_index_o (bucket_index_o),
    .block_end_o    (block_end_o),
    .block_length_o (block_length_o)
  );

`ifndef SYNTH
  // Only body-byte events carry a block length or a block end flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != EV_BYTE) |-> (block_length_o == '0) && !block_end_o)
    else $error("non-byte event carries block information");

  // A body byte always advances the fill count, and never past a full block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_BYTE) |->
      (block_length_o != '0) && (block_length_o <= FILL_W'(BLOCK_BYTES)))
    else $error("block length out of range");

  // A full block must be flagged as a block end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_BYTE) && (block_length_o == FILL_W'(BLOCK_BYTES))
      |-> block_end_o)
    else $error("full block not marked as block end");

  // The queue never takes a command while it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_pop |=> $stable(u_queue.count_q) || !q_full)
    else $error("command queue overflow");
`endif

endmodule
`default_nettype wire

[hdl/lpbd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/lpbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbd_front
// Header parser and byte classifier; holds the configuration registers.
// ----------------------------------------------------------------------------
module lpbd_front
  import lpbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  input  wire logic [7:0]            byte_in_i,
  input  wire logic                  q_full_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output cmd_t                       cmd_o
);

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  hdr_pos_q;
  logic [15:0]       hdr_bucket_q;
  logic [55:0]       hdr_len_q;
  logic [63:0]       body_left_q;
  logic [IDX_W-1:0]  cur_idx_q;
  logic [6:0]        live_q;
  logic [15:0]       base_q;
  logic [6:0]        count_q;

  logic              accept;
  logic              last_hdr;
  logic [63:0]       full_len;
  logic [15:0]       local_idx;
  logic              bucket_miss;
  logic              len_zero;
  logic [6:0]        live_dec;
  logic              body_end;

  assign accept      = in_valid_i && !q_full_i;
  assign in_stall_o  = q_full_i;
  assign last_hdr    = hdr_pos_q == POS_W'(HDR_BYTES - 1);
  assign full_len    = {byte_in_i, hdr_len_q};
  assign local_idx   = hdr_bucket_q - base_q;
  assign bucket_miss = (local_idx >= {9'd0, count_q}) || (local_idx >= 16'(NUM_BUCKETS));
  assign len_zero    = full_len == 64'd0;
  assign live_dec    = (live_q != 7'd0) ? live_q - 7'd1 : 7'd0;
  assign body_end    = body_left_q <= 64'd1;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (accept && last_hdr) begin
          if (bucket_miss) begin
            phase_d = len_zero ? PH_HEADER : PH_SKIP;
          end else if (len_zero) begin
            phase_d = (live_dec == 7'd0) ? PH_DONE : PH_HEADER;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY, PH_SKIP: begin
        if (accept && body_end) begin
          phase_d = PH_HEADER;
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_HEADER;
    endcase
  end

  // Command issued for the accepted byte.
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = EV_BYTE;
    cmd_o.data  = 8'd0;
    cmd_o.idx   = '0;
    cmd_o.last  = 1'b0;
    unique case (phase_q)
      PH_HEADER: begin
        if (accept && last_hdr) begin
          if (bucket_miss) begin
            push_o     = 1'b1;
            cmd_o.kind = EV_BAD_BUCKET;
          end else if (len_zero) begin
            push_o     = 1'b1;
            cmd_o.kind = (live_dec == 7'd0) ? EV_STREAM_DONE : EV_BUCKET_END;
            cmd_o.idx  = local_idx[IDX_W-1:0];
          end
        end
      end
      PH_BODY: begin
        push_o     = accept;
        cmd_o.kind = EV_BYTE;
        cmd_o.data = byte_in_i;
        cmd_o.idx  = cur_idx_q;
        cmd_o.last = body_end;
      end
      PH_DONE: begin
        push_o     = accept;
        cmd_o.kind = EV_AFTER_DONE;
      end
      PH_SKIP: push_o = 1'b0;
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hdr_pos_q    <= '0;
      hdr_bucket_q <= '0;
      hdr_len_q    <= '0;
      body_left_q  <= '0;
      cur_idx_q    <= '0;
      live_q       <= 7'(NUM_BUCKETS);
      base_q       <= '0;
      count_q      <= 7'(NUM_BUCKETS);
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        case (phase_q)
          PH_HEADER: begin
            if (last_hdr) begin
              hdr_pos_q   <= '0;
              body_left_q <= full_len;
              if (!bucket_miss) begin
                cur_idx_q <= local_idx[IDX_W-1:0];
                if (len_zero) begin
                  live_q <= live_dec;
                end
              end
            end else begin
              hdr_pos_q <= hdr_pos_q + POS_W'(1);
            end
            case (hdr_pos_q)
              4'd0:    hdr_bucket_q[7:0]  <= byte_in_i;
              4'd1:    hdr_bucket_q[15:8] <= byte_in_i;
              4'd2:    hdr_len_q[7:0]     <= byte_in_i;
              4'd3:    hdr_len_q[15:8]    <= byte_in_i;
              4'd4:    hdr_len_q[23:16]   <= byte_in_i;
              4'd5:    hdr_len_q[31:24]   <= byte_in_i;
              4'd6:    hdr_len_q[39:32]   <= byte_in_i;
              4'd7:    hdr_len_q[47:40]   <= byte_in_i;
              4'd8:    hdr_len_q[55:48]   <= byte_in_i;
              default: hdr_len_q          <= hdr_len_q;
            endcase
          end
          PH_BODY, PH_SKIP: begin
            if (body_left_q != 64'd0) begin
              body_left_q <= body_left_q - 64'd1;
            end
          end
          default: body_left_q <= body_left_q;
        endcase
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BUCKET_BASE) begin
          base_q <= cfg_wdata_i;
        end else if (cfg_idx_i == REG_BUCKET_COUNT) begin
          count_q <= cfg_wdata_i[6:0];
          live_q  <= cfg_wdata_i[6:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/lpbd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbd_queue
// Short command queue between the parser and the fill-count stage.
// ----------------------------------------------------------------------------
module lpbd_queue
  import lpbd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/lpbd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpbd_back
// Per-bucket fill counting and the output register.
// ----------------------------------------------------------------------------
module lpbd_back
  import lpbd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire cmd_t              q_cmd_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             event_res_o,
  output logic [7:0]             data_out_o,
  output logic [IDX_W-1:0]       bucket_index_o,
  output logic                   block_end_o,
  output logic [FILL_W-1:0]      block_length_o
);

  logic               s1_valid_q;
  cmd_t               s1_cmd_q;
  logic               s1_adv, s1_free;
  logic               rd_en;

  logic [NUM_BUCKETS-1:0] written_q;
  logic               rvalid_q;
  logic               fwd_q;
  logic [FILL_W-1:0]  fwd_val_q;
  logic [FILL_W-1:0]  rdata;
  logic [FILL_W-1:0]  stored;
  logic [FILL_W-1:0]  fill;
  logic               bend;
  logic               wr_en;
  logic [FILL_W-1:0]  wr_val;

  logic               out_valid_q;
  logic [2:0]         ev_q;
  logic [7:0]         data_q;
  logic [IDX_W-1:0]   idx_q;
  logic               bend_q;
  logic [FILL_W-1:0]  len_q;

  assign s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free = !s1_valid_q || s1_adv;
  assign q_pop_o = q_valid_i && s1_free;
  assign rd_en   = q_pop_o && (q_cmd_i.kind == EV_BYTE);

  // A write at the same edge as the read is not seen by the RAM port; it is
  // caught by the forwarding register instead.
  assign stored = fwd_q ? fwd_val_q : (rvalid_q ? rdata : '0);
  assign fill   = stored + FILL_W'(1);
  assign bend   = (fill >= FILL_W'(BLOCK_BYTES)) || s1_cmd_q.last;
  assign wr_en  = s1_adv && (s1_cmd_q.kind == EV_BYTE);
  assign wr_val = bend ? '0 : fill;

  lpbd_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_cmd_q.idx),
    .wdata_i (wr_val),
    .re_i    (rd_en),
    .raddr_i (q_cmd_i.idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_cmd_q  <= q_cmd_i;
      rvalid_q  <= written_q[q_cmd_i.idx];
      fwd_q     <= wr_en && (s1_cmd_q.idx == q_cmd_i.idx);
      fwd_val_q <= wr_val;
    end
    if (s1_adv) begin
      ev_q   <= s1_cmd_q.kind;
      data_q <= (s1_cmd_q.kind == EV_BYTE) ? s1_cmd_q.data : 8'd0;
      idx_q  <= s1_cmd_q.idx;
      bend_q <= (s1_cmd_q.kind == EV_BYTE) && bend;
      len_q  <= (s1_cmd_q.kind == EV_BYTE) ? fill : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= q_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        written_q[s1_cmd_q.idx] <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign data_out_o     = data_q;
  assign bucket_index_o = idx_q;
  assign block_end_o    = bend_q;
  assign block_length_o = len_q;

endmodule
`default_nettype wire
